// ----- src/physical_page_bitmap_allocator_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the page bitmap allocator checker.
// ----------------------------------------------------------------------------
`ifndef PHYSICAL_PAGE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define PHYSICAL_PAGE_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppba check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppba check failed");

`endif

// ----- src/ppba_pkg.sv -----
// ----------------------------------------------------------------------------
// ppba_pkg
// Shared constants, types and helper functions of the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppba_pkg;

    // Bitmap geometry.
    localparam int BITMAP_WORDS = 32768;
    localparam int WORD_BITS    = 32;
    localparam int BIT_IDX_W    = 5;
    localparam int PAGE_SHIFT   = 12;
    localparam int TOTAL_PAGES  = BITMAP_WORDS * WORD_BITS;

    // Word index, word count and free page count widths.
    localparam int WIDX_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int WCNT_W = $clog2(BITMAP_WORDS + 1);
    localparam int CNT_W  = $clog2(TOTAL_PAGES + 1);

    // Page bound width: (33-bit byte sum) >> 12.
    localparam int PGX_W = 33 - PAGE_SHIFT;

    // Field widths.
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 32;
    localparam int RTYPE_W  = 8;
    localparam int FREE_W   = 21;
    localparam int CFG_W    = 16;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 56;
    localparam int M_PAD_W  = M_DATA_W - ADDR_W - FREE_W;

    localparam logic [WORD_BITS-1:0] FULL_WORD       = '1;
    localparam logic [RTYPE_W-1:0]   REGION_USABLE   = 8'd1;
    localparam logic [CFG_W-1:0]     LOW_WORDS_RESET = 16'd8;

    typedef enum logic [1:0] {
        KIND_ALLOC_HIGH = 2'd0,
        KIND_ALLOC_LOW  = 2'd1,
        KIND_FREE       = 2'd2,
        KIND_MARK       = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init_write;
        logic high_step;
        logic low_step;
        logic take;
        logic free_read;
        logic free_apply;
        logic mark_bounds;
        logic mark_limit;
        logic mark_setup;
        logic mark_read;
        logic mark_apply;
        logic emit;
    } ppba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_last;
        logic high_done;
        logic low_done;
        logic word_full;
        logic free_in_range;
        logic mark_usable;
        logic mark_empty;
        logic mark_last;
        logic out_room;
    } ppba_status_t;

    function automatic logic [2:0] pop4(input logic [3:0] v);
        return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
    endfunction

    // Population count as a sum of eight nibble counts.
    function automatic logic [5:0] pop32(input logic [31:0] v);
        logic [5:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {3'b000, pop4(v[4*i +: 4])};
        end
        return s;
    endfunction

    // Index of the lowest clear bit; the word must not be full.
    function automatic logic [BIT_IDX_W-1:0] low_zero_idx(input logic [31:0] w);
        logic [31:0]          inv;
        logic [31:0]          one;
        logic [BIT_IDX_W-1:0] idx;
        inv = ~w;
        one = inv & (~inv + 32'd1);
        idx = '0;
        for (int k = 0; k < BIT_IDX_W; k++) begin
            for (int i = 0; i < 32; i++) begin
                if (((i >> k) & 1) == 1) begin
                    idx[k] = idx[k] | one[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

// ----- src/physical_page_bitmap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// Physical page bitmap allocator
// Bitmap of 4 KiB pages (1 = used) with high/low allocation, page free and
// usable-region marking.
// ----------------------------------------------------------------------------
// Usage:
// An operation item enters on the s_axis channel; tuser carries the kind
// (alloc high, alloc low, free, mark region). Each item yields exactly one
// result item on m_axis: ok flag in tuser, page address and free page count
// in tdata. low_region_words is written on the cfg channel, which is always
// ready and should only be written while the block is idle.
// One item is worked at a time, paced by the bitmap memory. An allocation
// reads the bitmap word by word until it finds a word with a clear bit,
// a free reads the page's word and clears its bit, and marking a usable
// region reads and rewrites each word that it covers; other region types
// touch no word. The result is valid from the cycle in which the input is
// ready again.
// After reset the bitmap is filled with ones, one word per cycle, so inputs
// are held off until every word is written; configuration writes are
// taken meanwhile. A finished result sits in the output register while the
// next item is accepted; if the receiver stalls, the following result waits
// inside the block until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module physical_page_bitmap_allocator_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // address [31:0], region_length [63:32], region_type [71:64]
    input  wire logic [ppba_pkg::S_DATA_W-1:0]     s_axis_tdata,
    // kind [1:0]
    input  wire logic [1:0]                        s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // page_address [31:0], free_pages [52:32], zero [55:53]
    output logic [ppba_pkg::M_DATA_W-1:0]          m_axis_tdata,
    // ok [0]
    output logic [0:0]                             m_axis_tuser,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ppba_pkg::CFG_W-1:0]        cfg_data
);
    import ppba_pkg::*;

    ppba_cmd_t         cmd;
    ppba_status_t      status;
    kind_t             in_kind;
    logic              out_ok;
    logic [ADDR_W-1:0] out_page;
    logic [FREE_W-1:0] out_free;

    assign in_kind   = kind_t'(s_axis_tuser);
    assign cfg_ready = 1'b1;

    ppba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (in_kind),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ppba_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_kind    (in_kind),
        .in_address (s_axis_tdata[31:0]),
        .in_length  (s_axis_tdata[63:32]),
        .in_rtype   (s_axis_tdata[71:64]),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ok     (out_ok),
        .out_page   (out_page),
        .out_free   (out_free)
    );

    assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_free, out_page};
    assign m_axis_tuser = out_ok;

endmodule

`default_nettype wire

// ----- src/ppba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ppba_ctrl
// Controller state machine: sequences the bitmap fill pass, the scans,
// page free, region marking and the hand-off of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppba_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire ppba_pkg::kind_t        in_kind,
    output logic                        in_ready,
    output ppba_pkg::ppba_cmd_t         cmd,
    input  wire ppba_pkg::ppba_status_t status
);
    import ppba_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_H_STEP,
        ST_H_CHECK,
        ST_L_STEP,
        ST_L_CHECK,
        ST_F_READ,
        ST_F_CHECK,
        ST_M_BOUNDS,
        ST_M_LIMIT,
        ST_M_SETUP,
        ST_M_READ,
        ST_M_APPLY,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_write = 1'b1;
                if (status.init_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    case (in_kind)
                        KIND_ALLOC_HIGH: state_next = ST_H_STEP;
                        KIND_ALLOC_LOW:  state_next = ST_L_STEP;
                        KIND_FREE:       state_next = ST_F_READ;
                        KIND_MARK:       state_next = ST_M_BOUNDS;
                        default:         state_next = ST_RESULT;
                    endcase
                end
            end
            ST_H_STEP:
            begin
                if (status.high_done)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.high_step = 1'b1;
                    state_next    = ST_H_CHECK;
                end
            end
            ST_H_CHECK:
            begin
                if (status.word_full)
                begin
                    state_next = ST_H_STEP;
                end
                else
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_L_STEP:
            begin
                if (status.low_done)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.low_step = 1'b1;
                    state_next   = ST_L_CHECK;
                end
            end
            ST_L_CHECK:
            begin
                if (status.word_full)
                begin
                    state_next = ST_L_STEP;
                end
                else
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_F_READ:
            begin
                if (status.free_in_range)
                begin
                    cmd.free_read = 1'b1;
                    state_next    = ST_F_CHECK;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_F_CHECK:
            begin
                cmd.free_apply = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_M_BOUNDS:
            begin
                if (status.mark_usable)
                begin
                    cmd.mark_bounds = 1'b1;
                    state_next      = ST_M_LIMIT;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_M_LIMIT:
            begin
                cmd.mark_limit = 1'b1;
                state_next     = ST_M_SETUP;
            end
            ST_M_SETUP:
            begin
                if (status.mark_empty)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cmd.mark_setup = 1'b1;
                    state_next     = ST_M_READ;
                end
            end
            ST_M_READ:
            begin
                cmd.mark_read = 1'b1;
                state_next    = ST_M_APPLY;
            end
            ST_M_APPLY:
            begin
                cmd.mark_apply = 1'b1;
                state_next     = status.mark_last ? ST_RESULT : ST_M_READ;
            end
            ST_RESULT:
            begin
                if (status.out_room)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/ppba_dp.sv -----
// ----------------------------------------------------------------------------
// ppba_dp
// Datapath: bitmap memory, scan and region registers, free page counter,
// configuration register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppba_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ppba_pkg::ppba_cmd_t             cmd,
    output ppba_pkg::ppba_status_t               status,
    input  wire ppba_pkg::kind_t                 in_kind,
    input  wire logic [ppba_pkg::ADDR_W-1:0]     in_address,
    input  wire logic [ppba_pkg::LEN_W-1:0]      in_length,
    input  wire logic [ppba_pkg::RTYPE_W-1:0]    in_rtype,
    input  wire logic                            cfg_valid,
    input  wire logic [ppba_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic                                 out_ok,
    output logic [ppba_pkg::ADDR_W-1:0]          out_page,
    output logic [ppba_pkg::FREE_W-1:0]          out_free
);
    import ppba_pkg::*;

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];

    // Control state.
    logic [WIDX_W-1:0] init_reg;
    logic [WCNT_W-1:0] search_limit_reg;
    logic [CNT_W-1:0]  free_count_reg;
    logic [CFG_W-1:0]  low_words_reg;
    logic              out_valid_reg;

    // Payload.
    logic [ADDR_W-1:0]    address_reg;
    logic [LEN_W-1:0]     length_reg;
    logic [RTYPE_W-1:0]   rtype_reg;
    logic [WCNT_W-1:0]    scan_reg;
    logic [WIDX_W-1:0]    addr_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 res_ok_reg;
    logic [ADDR_W-1:0]    res_page_reg;
    logic [PGX_W-1:0]     first_reg;
    logic [PGX_W-1:0]     last_reg;
    logic [WIDX_W-1:0]    mw_reg;
    logic [WIDX_W-1:0]    wfirst_reg;
    logic [WIDX_W-1:0]    wlast_reg;
    logic [BIT_IDX_W-1:0] lo_reg;
    logic [BIT_IDX_W-1:0] hi_reg;
    logic                 out_ok_reg;
    logic [ADDR_W-1:0]    out_page_reg;
    logic [FREE_W-1:0]    out_free_reg;

    // Combinational terms.
    logic [WCNT_W-1:0]    low_eff;
    logic [WCNT_W-1:0]    scan_dec;
    logic                 rd_en;
    logic [WIDX_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [WIDX_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [BIT_IDX_W-1:0] take_bit;
    logic [BIT_IDX_W-1:0] free_bit;
    logic                 free_hit;
    logic [32:0]          first_sum;
    logic [32:0]          last_sum;
    logic [PGX_W:0]       need;
    logic [PGX_W:0]       limit;
    logic [PGX_W-1:0]     last_m1;
    logic [BIT_IDX_W-1:0] lo_eff;
    logic [BIT_IDX_W-1:0] hi_eff;
    logic [WORD_BITS-1:0] mark_mask;
    logic [5:0]           mark_pop;

    assign low_eff  = (32'(low_words_reg) > 32'(BITMAP_WORDS)) ? WCNT_W'(BITMAP_WORDS)
                                                               : WCNT_W'(low_words_reg);
    assign scan_dec = scan_reg - WCNT_W'(1);
    assign take_bit = low_zero_idx(rd_data_reg);
    assign free_bit = address_reg[PAGE_SHIFT +: BIT_IDX_W];
    assign free_hit = rd_data_reg[free_bit];

    assign first_sum = {1'b0, address_reg} + 33'h0_0000_0FFF;
    assign last_sum  = {1'b0, address_reg} + {1'b0, length_reg};
    assign need      = ({1'b0, last_reg} + (PGX_W+1)'(31)) >> BIT_IDX_W;
    assign limit     = (need > (PGX_W+1)'(BITMAP_WORDS)) ? (PGX_W+1)'(BITMAP_WORDS) : need;
    assign last_m1   = last_reg - PGX_W'(1);

    // Partial masks at the first and last word of a region.
    assign lo_eff    = (mw_reg == wfirst_reg) ? lo_reg : '0;
    assign hi_eff    = (mw_reg == wlast_reg) ? hi_reg : '1;
    assign mark_mask = (FULL_WORD >> (~hi_eff)) & (FULL_WORD << lo_eff);
    assign mark_pop  = pop32(rd_data_reg & mark_mask);

    always_comb
    begin
        rd_en   = cmd.high_step | cmd.low_step | cmd.free_read | cmd.mark_read;
        rd_addr = mw_reg;
        if (cmd.high_step)
        begin
            rd_addr = scan_dec[WIDX_W-1:0];
        end
        else if (cmd.low_step)
        begin
            rd_addr = scan_reg[WIDX_W-1:0];
        end
        else if (cmd.free_read)
        begin
            rd_addr = address_reg[PAGE_SHIFT + BIT_IDX_W +: WIDX_W];
        end
    end

    always_comb
    begin
        wr_en   = cmd.init_write | cmd.take | (cmd.free_apply & free_hit) | cmd.mark_apply;
        wr_addr = cmd.init_write ? init_reg : addr_reg;
        wr_data = FULL_WORD;
        if (cmd.take)
        begin
            wr_data = rd_data_reg | (32'd1 << take_bit);
        end
        else if (cmd.free_apply)
        begin
            wr_data = rd_data_reg & ~(32'd1 << free_bit);
        end
        else if (cmd.mark_apply)
        begin
            wr_data = rd_data_reg & ~mark_mask;
        end
    end

    always_comb
    begin
        status.init_last     = (init_reg == WIDX_W'(BITMAP_WORDS - 1));
        status.high_done     = (scan_reg == '0);
        status.low_done      = (scan_reg >= low_eff);
        status.word_full     = (rd_data_reg == FULL_WORD);
        status.free_in_range = (32'(address_reg[ADDR_W-1:PAGE_SHIFT+BIT_IDX_W])
                                < 32'(BITMAP_WORDS));
        status.mark_usable   = (rtype_reg == REGION_USABLE);
        status.mark_empty    = (first_reg >= last_reg);
        status.mark_last     = (mw_reg == wlast_reg);
        status.out_room      = !out_valid_reg || out_ready;
    end

    // Bitmap memory: one read and one write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg         <= '0;
            search_limit_reg <= '0;
            free_count_reg   <= '0;
            low_words_reg    <= LOW_WORDS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.init_write)
            begin
                init_reg <= init_reg + WIDX_W'(1);
            end
            if (cfg_valid)
            begin
                low_words_reg <= cfg_data;
            end
            if (cmd.mark_limit && ((PGX_W+1)'(search_limit_reg) < limit))
            begin
                search_limit_reg <= WCNT_W'(limit);
            end
            if (cmd.take && (free_count_reg != '0))
            begin
                free_count_reg <= free_count_reg - CNT_W'(1);
            end
            else if (cmd.free_apply && free_hit)
            begin
                free_count_reg <= free_count_reg + CNT_W'(1);
            end
            else if (cmd.mark_apply)
            begin
                free_count_reg <= free_count_reg + CNT_W'(mark_pop);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            address_reg  <= in_address;
            length_reg   <= in_length;
            rtype_reg    <= in_rtype;
            scan_reg     <= (in_kind == KIND_ALLOC_HIGH) ? search_limit_reg : '0;
            res_ok_reg   <= 1'b0;
            res_page_reg <= '0;
        end
        if (rd_en)
        begin
            addr_reg <= rd_addr;
        end
        if (cmd.high_step)
        begin
            scan_reg <= scan_dec;
        end
        else if (cmd.low_step)
        begin
            scan_reg <= scan_reg + WCNT_W'(1);
        end
        if (cmd.take)
        begin
            res_ok_reg   <= 1'b1;
            res_page_reg <= ADDR_W'({addr_reg, take_bit}) << PAGE_SHIFT;
        end
        if (cmd.mark_bounds)
        begin
            first_reg <= first_sum[32:PAGE_SHIFT];
            last_reg  <= last_sum[32:PAGE_SHIFT];
        end
        if (cmd.mark_limit && ({1'b0, last_reg} > (PGX_W+1)'(TOTAL_PAGES)))
        begin
            last_reg <= PGX_W'(TOTAL_PAGES);
        end
        if (cmd.mark_setup)
        begin
            mw_reg     <= first_reg[BIT_IDX_W +: WIDX_W];
            wfirst_reg <= first_reg[BIT_IDX_W +: WIDX_W];
            wlast_reg  <= last_m1[BIT_IDX_W +: WIDX_W];
            lo_reg     <= first_reg[BIT_IDX_W-1:0];
            hi_reg     <= last_m1[BIT_IDX_W-1:0];
        end
        if (cmd.mark_apply)
        begin
            mw_reg <= mw_reg + WIDX_W'(1);
        end
        if (cmd.emit)
        begin
            out_ok_reg   <= res_ok_reg;
            out_page_reg <= res_page_reg;
            out_free_reg <= FREE_W'(free_count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ok    = out_ok_reg;
    assign out_page  = out_page_reg;
    assign out_free  = out_free_reg;

endmodule

`default_nettype wire

// ----- src/ppba_checker.sv -----
// ----------------------------------------------------------------------------
// ppba_checker
// Port-level checks of the page bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "physical_page_bitmap_allocator_unit_macros.svh"

module ppba_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [ppba_pkg::M_DATA_W-1:0]     m_axis_tdata,
    input  wire logic [0:0]                        m_axis_tuser
);
    import ppba_pkg::*;

    // A stalled result holds still.
    `PPBA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // A failed or non-allocating item reports page address zero.
    `PPBA_ASSERT_IMPLY(a_fail_zero, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[31:0] == 32'd0)

    // The free page count never exceeds the bitmap size.
    `PPBA_ASSERT_IMPLY(a_count_bound, clk, rst_n, m_axis_tvalid, 32'(m_axis_tdata[52:32]) <= 32'(TOTAL_PAGES))

    // Items are worked one at a time: the cycle after an accept is busy.
    `PPBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind physical_page_bitmap_allocator_unit ppba_checker u_ppba_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the physical page bitmap allocator
// Drives alloc-high, alloc-low, page free and region-mark items into the
// block, predicts each result from a bit-accurate copy of the page bitmap,
// and checks every result item with random idling and stalls on both sides.
// ----------------------------------------------------------------------------

module tb;

    import ppba_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned SCAN_GUARD  = 256;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned WINDOW_PAGES = 2048;

    typedef struct packed {
        logic                ok;
        logic [ADDR_W-1:0]   page_address;
        logic [FREE_W-1:0]   free_pages;
    } alloc_result_t;

    class page_alloc_scoreboard;
        logic [WORD_BITS-1:0] usage [BITMAP_WORDS];
        int unsigned          limit_words;
        int unsigned          free_total;
        logic [CFG_W-1:0]     low_words;
        alloc_result_t        expected_q [$];
        int unsigned          errors;
        int unsigned          checked;
        int unsigned          granted;
        int unsigned          refused;
        int unsigned          frees;
        int unsigned          marks;

        function new();
            foreach (usage[i])
                usage[i] = FULL_WORD;
            limit_words = 0;
            free_total  = 0;
            low_words   = LOW_WORDS_RESET;
            errors      = 0;
            checked     = 0;
            granted     = 0;
            refused     = 0;
            frees       = 0;
            marks       = 0;
        endfunction

        function void set_low_words(logic [CFG_W-1:0] v);
            low_words = v;
        endfunction

        function int unsigned low_span();
            return (low_words > BITMAP_WORDS) ? BITMAP_WORDS : low_words;
        endfunction

        // Number of bitmap words an allocation would read before it stops.
        function int unsigned scan_cost(kind_t k);
            int unsigned w;
            int unsigned n;
            n = 0;
            if (k == KIND_ALLOC_HIGH) begin
                w = limit_words;
                while (w > 0) begin
                    w--;
                    n++;
                    if (usage[w] != FULL_WORD)
                        break;
                end
            end
            else if (k == KIND_ALLOC_LOW) begin
                for (w = 0; w < low_span(); w++) begin
                    n++;
                    if (usage[w] != FULL_WORD)
                        break;
                end
            end
            return n;
        endfunction

        function logic [ADDR_W-1:0] take_page(int unsigned w);
            int unsigned b;
            for (b = 0; b < WORD_BITS - 1; b++) begin
                if (!usage[w][b])
                    break;
            end
            usage[w][b] = 1'b1;
            if (free_total > 0)
                free_total--;
            return (w * WORD_BITS + b) << PAGE_SHIFT;
        endfunction

        function void mark_usable(logic [ADDR_W-1:0] base, logic [LEN_W-1:0] len);
            logic [63:0]          first_pg;
            logic [63:0]          end_pg;
            logic [63:0]          need;
            int unsigned          w;
            int unsigned          wlo;
            int unsigned          whi;
            int unsigned          lo;
            int unsigned          hi;
            logic [WORD_BITS-1:0] mask;
            first_pg = ({32'd0, base} + 64'hFFF) >> PAGE_SHIFT;
            end_pg   = ({32'd0, base} + {32'd0, len}) >> PAGE_SHIFT;
            need     = (end_pg + 64'd31) >> 5;
            if (need > BITMAP_WORDS)
                need = BITMAP_WORDS;
            if (need > limit_words)
                limit_words = int'(need);
            if (end_pg > TOTAL_PAGES)
                end_pg = TOTAL_PAGES;
            if (first_pg >= end_pg)
                return;
            end_pg = end_pg - 64'd1;
            wlo = int'(first_pg >> 5);
            whi = int'(end_pg >> 5);
            for (w = wlo; w <= whi; w++) begin
                lo   = (w == wlo) ? first_pg[4:0] : 0;
                hi   = (w == whi) ? end_pg[4:0] : 31;
                mask = (FULL_WORD >> (31 - hi)) & (FULL_WORD << lo);
                free_total += $countones(usage[w] & mask);
                usage[w] &= ~mask;
            end
        endfunction

        function void note_op(kind_t k, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                              logic [RTYPE_W-1:0] rtype);
            alloc_result_t res;
            int unsigned   w;
            logic [4:0]    b;
            res = '0;
            case (k)
                KIND_ALLOC_HIGH:
                begin
                    w = limit_words;
                    while (w > 0) begin
                        w--;
                        if (usage[w] != FULL_WORD) begin
                            res.ok = 1'b1;
                            res.page_address = take_page(w);
                            break;
                        end
                    end
                end
                KIND_ALLOC_LOW:
                begin
                    for (w = 0; w < low_span(); w++) begin
                        if (usage[w] != FULL_WORD) begin
                            res.ok = 1'b1;
                            res.page_address = take_page(w);
                            break;
                        end
                    end
                end
                KIND_FREE:
                begin
                    frees++;
                    w = addr >> (PAGE_SHIFT + BIT_IDX_W);
                    b = addr[PAGE_SHIFT +: BIT_IDX_W];
                    if (w < BITMAP_WORDS && usage[w][b]) begin
                        usage[w][b] = 1'b0;
                        free_total++;
                    end
                end
                default:
                begin
                    marks++;
                    if (rtype == REGION_USABLE)
                        mark_usable(addr, len);
                end
            endcase
            if (k == KIND_ALLOC_HIGH || k == KIND_ALLOC_LOW) begin
                if (res.ok)
                    granted++;
                else
                    refused++;
            end
            res.free_pages = free_total[FREE_W-1:0];
            expected_q.push_back(res);
        endfunction

        function void check_result(logic ok, logic [ADDR_W-1:0] page, logic [FREE_W-1:0] nfree);
            alloc_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual ok %0d page %h free %0d",
                         $time, ok, page, nfree);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (ok !== want.ok) begin
                errors++;
                $display("%0t: ok mismatch, expected %0d, actual %0d", $time, want.ok, ok);
            end
            if (page !== want.page_address) begin
                errors++;
                $display("%0t: page_address mismatch, expected %h, actual %h",
                         $time, want.page_address, page);
            end
            if (nfree !== want.free_pages) begin
                errors++;
                $display("%0t: free_pages mismatch, expected %0d, actual %0d",
                         $time, want.free_pages, nfree);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [0:0]          m_axis_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data = '0;

    page_alloc_scoreboard sb;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_stall_pct = 0;
    logic                 holding = 1'b0;
    int unsigned          cycle_count = 0;
    event                 hold_go;

    physical_page_bitmap_allocator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
    begin
        m_axis_tready <= holding ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial
    begin
        forever begin
            @(hold_go);
            holding = 1'b1;
            repeat (LONG_HOLD) @(posedge clk);
            holding = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tdata[52:32]);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_op(input kind_t k, input logic [ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic [RTYPE_W-1:0] rtype);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rtype, len, addr};
        s_axis_tuser  <= k;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_op(k, addr, len, rtype);
        @(negedge clk);
    endtask

    task automatic write_low_words(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_low_words(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.expected_q.size() != 0);
    endtask

    task automatic issue_random_op(input int unsigned span_pages, input bit guarded);
        kind_t              k;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   len;
        logic [RTYPE_W-1:0] rtype;
        int unsigned        r;
        int unsigned        pick;
        r     = $urandom_range(0, 99);
        addr  = $urandom();
        len   = $urandom();
        rtype = 8'($urandom_range(0, 255));
        if (r < 24)
            k = KIND_ALLOC_HIGH;
        else if (r < 44)
            k = KIND_ALLOC_LOW;
        else if (r < 70)
            k = KIND_FREE;
        else
            k = KIND_MARK;
        // Long scans over a full bitmap are slow; a free is sent instead.
        if (guarded && (k == KIND_ALLOC_HIGH || k == KIND_ALLOC_LOW)
            && sb.scan_cost(k) > SCAN_GUARD)
            k = KIND_FREE;
        if (k == KIND_FREE && $urandom_range(0, 9) != 0)
            addr = ($urandom_range(0, span_pages - 1) << PAGE_SHIFT) | (addr & 32'hFFF);
        if (k == KIND_MARK) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // Non-usable types carry fully random fields and are ignored.
                if (rtype == REGION_USABLE)
                    rtype = 8'd2;
            end
            else begin
                rtype = REGION_USABLE;
                addr  = ($urandom_range(0, span_pages - 1) << PAGE_SHIFT) | (addr & 32'hFFF);
                if ($urandom_range(0, 3) == 0)
                    addr[PAGE_SHIFT-1:0] = '0;
                if (pick < 20)
                    len = $urandom_range(0, 32'h1000);
                else if (pick < 85)
                    len = $urandom_range(0, 32'h10000);
                else
                    len = $urandom_range(0, 32'h100000);
            end
        end
        send_op(k, addr, len, rtype);
    endtask

    task automatic run_phase(input int unsigned n_ops, input logic [CFG_W-1:0] low_words,
                             input int unsigned idle_pct, input int unsigned stall_pct,
                             input int unsigned span_pages);
        write_low_words(low_words);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_ops; i++) begin
            issue_random_op(span_pages, 1'b1);
            // Now and then the sender waits for every result before going on.
            if (i % 90 == 89 && i != n_ops - 1)
                drain();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // The register is written while the block is still filling its bitmap.
        write_low_words(16'd2);

        // Directed items on an all-used bitmap with a zero search limit.
        send_op(KIND_ALLOC_HIGH, 32'h0, 32'h0, 8'h0);
        send_op(KIND_ALLOC_LOW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_op(KIND_FREE, 32'hFFFF_FFFF, 32'h0, 8'h0);
        send_op(KIND_FREE, 32'hFFFF_F123, 32'h0, 8'h0);
        send_op(KIND_MARK, 32'h0, 32'hFFFF_FFFF, 8'h0);
        send_op(KIND_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_op(KIND_MARK, 32'h1800, 32'h0, REGION_USABLE);
        send_op(KIND_MARK, 32'h1001, 32'hFFE, REGION_USABLE);
        send_op(KIND_MARK, 32'h0, 32'h3000, REGION_USABLE);
        send_op(KIND_MARK, 32'h0, 32'h3000, REGION_USABLE);
        send_op(KIND_MARK, 32'h1FFFF, 32'h20001, REGION_USABLE);
        send_op(KIND_ALLOC_HIGH, 32'h0, 32'h0, 8'h0);
        send_op(KIND_ALLOC_LOW, 32'h0, 32'h0, 8'h0);
        send_op(KIND_FREE, 32'h20000, 32'h0, 8'h0);
        send_op(KIND_FREE, 32'h0, 32'h0, 8'h0);
        send_op(KIND_ALLOC_HIGH, 32'h0, 32'h0, 8'h0);
        send_op(KIND_ALLOC_LOW, 32'h0, 32'h0, 8'h0);
        send_op(KIND_MARK, 32'h5000, 32'h1000, REGION_USABLE);
        send_op(KIND_ALLOC_LOW, 32'h0, 32'h0, 8'h0);
        drain();

        run_phase(180, 16'd8, 0, 0, WINDOW_PAGES);

        // The receiver holds off while frees keep coming, so the input stalls.
        @(posedge clk);
        -> hold_go;
        @(negedge clk);
        for (int i = 0; i < 24; i++)
            send_op(KIND_FREE, $urandom_range(0, WINDOW_PAGES - 1) << PAGE_SHIFT,
                    $urandom(), 8'($urandom_range(0, 255)));
        drain();

        run_phase(180, 16'd0, 65, 0, WINDOW_PAGES);
        run_phase(180, 16'hFFFF, 0, 65, WINDOW_PAGES);
        run_phase(180, 16'd32768, 8, 8, WINDOW_PAGES);
        run_phase(180, 16'd1, 30, 30, WINDOW_PAGES);

        // Saturate the search limit, then free the whole bitmap.
        write_low_words(16'd40);
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        send_op(KIND_MARK, 32'hFFFF_F000, 32'hFFFF_FFFF, REGION_USABLE);
        repeat (6)
            send_op(KIND_ALLOC_HIGH, $urandom(), $urandom(), 8'($urandom_range(0, 255)));
        send_op(KIND_MARK, 32'h0, 32'hFFFF_FFFF, REGION_USABLE);
        send_op(KIND_MARK, 32'hFFFF_F000, 32'h1000, REGION_USABLE);
        send_op(KIND_ALLOC_HIGH, 32'h0, 32'h0, 8'h0);
        send_op(KIND_FREE, 32'hFFFF_F000, 32'h0, 8'h0);
        send_op(KIND_ALLOC_LOW, 32'h0, 32'h0, 8'h0);
        drain();

        run_phase(80, 16'd32768, 30, 30, TOTAL_PAGES);

        repeat (20) @(negedge clk);
        $display("Checked %0d results: %0d allocations granted, %0d refused, %0d frees, %0d marks.",
                 sb.checked, sb.granted, sb.refused, sb.frees, sb.marks);
        $display("Low-region sizes 0 to 65535 used; search limit ended at %0d words.",
                 sb.limit_words);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
